[rtl/recurrent_net_step_with_noise_macros.svh]
// Assertion helpers for the recurrent network step block
`ifndef RECURRENT_NET_STEP_WITH_NOISE_MACROS_SVH
`define RECURRENT_NET_STEP_WITH_NOISE_MACROS_SVH

// Check an implication on every clock edge outside reset
`define RNS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the cycle after the antecedent
`define RNS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rns_pkg.sv]
`default_nettype none
package rns_pkg;
  localparam int unsigned NeuronCount = 32;
  localparam int unsigned EdgeCount   = 78;
  localparam int unsigned ActW        = 15;
  localparam logic [31:0] GenReset    = 32'h6d2b79f5;
  localparam logic [31:0] SeedMix     = 32'h9e3779b9;
  localparam logic [14:0] ThrReset    = 15'd512;

  typedef enum logic [1:0] {
    REQ_SEED  = 2'd0,
    REQ_STEP  = 2'd1,
    REQ_RECON = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [0:0] {
    CFG_IDENTITY  = 1'b0,
    CFG_THRESHOLD = 1'b1
  } cfg_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] epoch_or_tick;
    logic [4:0]  sensory_mask;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  brain_class;
    logic [31:0] epoch_now;
    logic [63:0] neuron_levels;
  } out_word_t;

  typedef struct packed {
    logic [4:0] src;
    logic [4:0] dst;
    logic [2:0] sh;
    logic       add;
  } link_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED,
    ST_DECAY_RD,
    ST_DECAY,
    ST_EDGE_RD,
    ST_EDGE,
    ST_FIN_RD,
    ST_FIN,
    ST_COPY_RD,
    ST_COPY,
    ST_OUT_RD,
    ST_OUT,
    ST_EMIT
  } st_e;

  function automatic logic [31:0] xs32(input logic [31:0] v);
    logic [31:0] a;
    logic [31:0] b;
    a = v ^ (v << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

  function automatic link_t mk(input int s, input int d, input int h, input int a);
    link_t l;
    l.src = 5'(s);
    l.dst = 5'(d);
    l.sh  = 3'(h);
    l.add = 1'(a);
    return l;
  endfunction

  function automatic link_t link_at(input logic [6:0] e);
    link_t l;
    l = mk(0, 0, 0, 1);
    unique case (e)
      7'd0: l = mk(0,5,2,1);   7'd1: l = mk(1,6,2,1);   7'd2: l = mk(2,7,2,1);
      7'd3: l = mk(3,8,2,1);   7'd4: l = mk(4,9,2,1);
      7'd5: l = mk(5,6,3,1);   7'd6: l = mk(6,5,3,1);   7'd7: l = mk(6,7,3,1);
      7'd8: l = mk(7,6,3,1);   7'd9: l = mk(7,8,3,1);   7'd10: l = mk(8,7,3,1);
      7'd11: l = mk(8,9,3,1);  7'd12: l = mk(9,8,3,1);  7'd13: l = mk(9,10,3,1);
      7'd14: l = mk(10,9,3,1); 7'd15: l = mk(10,11,3,1); 7'd16: l = mk(11,10,3,1);
      7'd17: l = mk(11,12,3,1); 7'd18: l = mk(12,11,3,1); 7'd19: l = mk(12,5,3,1);
      7'd20: l = mk(5,12,3,1);
      7'd21: l = mk(5,9,4,0);  7'd22: l = mk(6,10,4,0); 7'd23: l = mk(7,11,4,0);
      7'd24: l = mk(8,12,4,0); 7'd25: l = mk(9,5,4,0);  7'd26: l = mk(10,6,4,0);
      7'd27: l = mk(11,7,4,0); 7'd28: l = mk(12,8,4,0);
      7'd29: l = mk(5,13,3,1); 7'd30: l = mk(6,14,3,1); 7'd31: l = mk(7,15,3,1);
      7'd32: l = mk(8,16,3,1); 7'd33: l = mk(9,17,3,1); 7'd34: l = mk(10,18,3,1);
      7'd35: l = mk(11,19,3,1); 7'd36: l = mk(12,20,3,1);
      7'd37: l = mk(13,16,4,1); 7'd38: l = mk(16,19,4,1); 7'd39: l = mk(19,22,4,1);
      7'd40: l = mk(22,13,4,1); 7'd41: l = mk(14,17,4,1); 7'd42: l = mk(17,20,4,1);
      7'd43: l = mk(20,23,4,1); 7'd44: l = mk(23,14,4,1); 7'd45: l = mk(15,18,4,1);
      7'd46: l = mk(18,21,4,1); 7'd47: l = mk(21,24,4,1); 7'd48: l = mk(24,15,4,1);
      7'd49: l = mk(13,20,5,0); 7'd50: l = mk(14,21,5,0); 7'd51: l = mk(15,22,5,0);
      7'd52: l = mk(16,23,5,0); 7'd53: l = mk(17,24,5,0); 7'd54: l = mk(18,13,5,0);
      7'd55: l = mk(25,26,5,1); 7'd56: l = mk(26,27,5,1); 7'd57: l = mk(27,28,5,1);
      7'd58: l = mk(28,25,5,1); 7'd59: l = mk(25,14,5,1); 7'd60: l = mk(26,17,5,1);
      7'd61: l = mk(27,20,5,1); 7'd62: l = mk(28,23,5,1);
      7'd63: l = mk(13,29,3,1); 7'd64: l = mk(16,29,3,1); 7'd65: l = mk(19,29,3,1);
      7'd66: l = mk(22,29,3,1); 7'd67: l = mk(14,30,3,1); 7'd68: l = mk(17,30,3,1);
      7'd69: l = mk(20,30,3,1); 7'd70: l = mk(23,30,3,1); 7'd71: l = mk(15,31,3,1);
      7'd72: l = mk(18,31,3,1); 7'd73: l = mk(21,31,3,1); 7'd74: l = mk(24,31,3,1);
      7'd75: l = mk(29,16,5,1); 7'd76: l = mk(30,19,5,1); 7'd77: l = mk(31,22,5,1);
      default: l = mk(0, 0, 0, 1);
    endcase
    return l;
  endfunction

  function automatic logic [14:0] mag15(input logic signed [14:0] v);
    logic signed [15:0] w;
    w = v;
    if (w < 0) w = -w;
    return 15'(w);
  endfunction

  function automatic logic [1:0] level_of(input logic signed [14:0] v);
    logic [14:0] m;
    m = mag15(v);
    if (m < 15'd128) return 2'd0;
    else if (m < 15'd256) return 2'd1;
    else if (m < 15'd512) return 2'd2;
    return 2'd3;
  endfunction
endpackage
`default_nettype wire

[rtl/rns_ram.sv]
`default_nettype none
module rns_ram #(
  parameter int unsigned Width = 15,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[rtl/rns_core.sv]
`default_nettype none
module rns_core #(
  parameter int unsigned NeuronCnt = rns_pkg::NeuronCount
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire rns_pkg::in_word_t   req_i,
  input  wire logic [31:0]         identity_i,
  input  wire logic [14:0]         threshold_i,
  output logic                     busy_o,
  output logic                     done_o,
  output rns_pkg::out_word_t       res_o
);
  import rns_pkg::*;
  localparam int unsigned AW = $clog2(NeuronCnt);

  // Activations in A, next-step accumulators in B
  logic              a_we, b_we;
  logic [AW-1:0]     a_wa, a_ra, b_wa, b_ra;
  logic [ActW-1:0]   a_wd, a_rd;
  logic [17:0]       b_wd, b_rd;

  rns_ram #(.Width(ActW), .Depth(NeuronCnt)) u_act (
    .clk_i, .we_i(a_we), .waddr_i(a_wa), .wdata_i(a_wd), .raddr_i(a_ra), .rdata_o(a_rd));
  rns_ram #(.Width(18), .Depth(NeuronCnt)) u_acc (
    .clk_i, .we_i(b_we), .waddr_i(b_wa), .wdata_i(b_wd), .raddr_i(b_ra), .rdata_o(b_rd));

  st_e              st_q, st_d;
  logic [AW-1:0]    n_q, n_d;
  logic [6:0]       e_q, e_d;
  logic [31:0]      gen_q, gen_d, epoch_q, epoch_d;
  logic [1:0]       cls_q, cls_d;
  logic [3:0]       steps_q, steps_d;
  logic [4:0]       mask_q, mask_d;
  logic [63:0]      lev_q, lev_d;
  logic signed [14:0] mv_q, mv_d, ar_q, ar_d, qu_q, qu_d;
  logic             init_q, init_d;
  logic [31:0]      seed, rnd;
  logic signed [17:0] sum, contrib;
  logic signed [14:0] act_now, nv, sv;
  link_t            lk;

  // Fresh activations after reset read zero until first written
  assign act_now = init_q ? $signed(a_rd) : '0;
  assign rnd     = xs32(gen_q);
  assign lk      = link_at(e_q);
  assign seed    = identity_i ^ (req_i.epoch_or_tick << 16)
                 ^ (req_i.epoch_or_tick >> 7) ^ SeedMix;

  function automatic logic signed [14:0] sat(input logic signed [17:0] v);
    if (v > 18'sd16383) return 15'sd16383;
    if (v < -18'sd16384) return -15'sd16384;
    return 15'(v);
  endfunction

  function automatic logic [1:0] classify(input logic signed [14:0] a29,
      input logic signed [14:0] a30, input logic signed [14:0] a31,
      input logic [14:0] th);
    logic [14:0] m, r, q;
    m = mag15(a29);
    r = mag15(a30);
    q = mag15(a31);
    if (m >= th && m >= r && m >= q) return 2'd1;
    else if (r >= th && r >= q) return 2'd2;
    else if (q >= th) return 2'd3;
    return 2'd0;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; n_q <= '0; e_q <= '0; gen_q <= GenReset; epoch_q <= '0;
      cls_q <= '0; steps_q <= '0; mask_q <= '0; lev_q <= '0; init_q <= 1'b0;
      mv_q <= '0; ar_q <= '0; qu_q <= '0;
    end else begin
      st_q <= st_d; n_q <= n_d; e_q <= e_d; gen_q <= gen_d; epoch_q <= epoch_d;
      cls_q <= cls_d; steps_q <= steps_d; mask_q <= mask_d; lev_q <= lev_d;
      init_q <= init_d; mv_q <= mv_d; ar_q <= ar_d; qu_q <= qu_d;
    end
  end

  // Sequence seed, decay, edge, finish and level sweeps
  always_comb begin
    st_d = st_q; n_d = n_q; e_d = e_q; gen_d = gen_q; epoch_d = epoch_q;
    cls_d = cls_q; steps_d = steps_q; mask_d = mask_q; lev_d = lev_q;
    init_d = init_q; mv_d = mv_q; ar_d = ar_q; qu_d = qu_q;
    a_we = 1'b0; a_wa = n_q; a_wd = '0; a_ra = n_q;
    b_we = 1'b0; b_wa = n_q; b_wd = '0; b_ra = n_q;
    sum = '0; contrib = '0; nv = '0; sv = '0;
    done_o = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (start_i) begin
          n_d = '0; mask_d = req_i.sensory_mask;
          unique case (req_e'(req_i.req_type))
            REQ_SEED: begin
              gen_d = (seed == '0) ? GenReset : seed;
              epoch_d = req_i.epoch_or_tick; steps_d = '0; st_d = ST_SEED;
            end
            REQ_RECON: begin
              gen_d = identity_i ^ ({3'b0, req_i.epoch_or_tick[31:3]} << 16)
                    ^ ({3'b0, req_i.epoch_or_tick[31:3]} >> 7) ^ SeedMix;
              if (gen_d == '0) gen_d = GenReset;
              epoch_d = {3'b0, req_i.epoch_or_tick[31:3]};
              steps_d = {1'b0, req_i.epoch_or_tick[2:0]} + 4'd1;
              st_d = ST_SEED;
            end
            REQ_STEP: begin steps_d = 4'd1; st_d = ST_DECAY_RD; end
            REQ_NONE: st_d = ST_OUT_RD;
            default: st_d = ST_OUT_RD;
          endcase
        end
      end
      // Fill activations with random values, one neuron a cycle
      ST_SEED: begin
        gen_d = rnd;
        if (n_q >= AW'(25) && n_q <= AW'(28))
          nv = 15'(18'(2) * ($signed({7'b0, rnd[10:0]}) - 18'sd1024));
        else nv = 15'($signed({6'b0, rnd[8:0]}) - 15'sd256);
        a_we = 1'b1; a_wd = nv;
        if (n_q == AW'(29)) mv_d = nv;
        if (n_q == AW'(30)) ar_d = nv;
        if (n_q == AW'(31)) qu_d = nv;
        n_d = n_q + 1'b1;
        if (n_q == AW'(NeuronCnt - 1)) begin
          init_d = 1'b1;
          cls_d = classify(mv_q, ar_q, nv, threshold_i);
          st_d = (steps_q == '0) ? ST_OUT_RD : ST_DECAY_RD;
        end
      end
      ST_DECAY_RD: begin a_ra = n_q; st_d = ST_DECAY; end
      ST_DECAY: begin
        b_we = 1'b1;
        b_wd = 18'(act_now >>> 1) + 18'(act_now >>> 2);
        if (n_q == AW'(NeuronCnt - 1)) begin
          e_d = '0; st_d = ST_EDGE_RD; n_d = '0;
        end else begin
          n_d = n_q + 1'b1; a_ra = n_q + 1'b1; st_d = ST_DECAY;
        end
      end
      // Each edge: read source and destination accumulator, then update
      ST_EDGE_RD: begin a_ra = lk.src; b_ra = lk.dst; st_d = ST_EDGE; end
      ST_EDGE: begin
        contrib = 18'(act_now >>> lk.sh);
        sum = lk.add ? $signed(b_rd) + contrib : $signed(b_rd) - contrib;
        b_we = 1'b1; b_wa = lk.dst; b_wd = sum;
        e_d = e_q + 1'b1;
        if (e_q == 7'(EdgeCount - 1)) begin n_d = '0; st_d = ST_FIN_RD; end
        else st_d = ST_EDGE_RD;
      end
      ST_FIN_RD: begin b_ra = n_q; st_d = ST_FIN; end
      // Drive, noise and saturation, written back to the activations
      ST_FIN: begin
        gen_d = rnd;
        sum = $signed(b_rd) + 18'($signed({1'b0, rnd[4:0]}) - 7'sd16);
        if (n_q < AW'(5) && mask_q[3'(n_q)]) sum = sum + 18'sd4096;
        sv = sat(sum);
        a_we = 1'b1; a_wd = sv;
        if (n_q == AW'(29)) mv_d = sv;
        if (n_q == AW'(30)) ar_d = sv;
        if (n_q == AW'(31)) qu_d = sv;
        n_d = n_q + 1'b1;
        if (n_q == AW'(NeuronCnt - 1)) begin
          init_d = 1'b1;
          epoch_d = epoch_q + 32'd1;
          cls_d = classify(mv_q, ar_q, sv, threshold_i);
          steps_d = steps_q - 4'd1;
          st_d = (steps_q == 4'd1) ? ST_OUT_RD : ST_DECAY_RD;
        end else st_d = ST_FIN_RD;
      end
      ST_COPY_RD: st_d = ST_OUT_RD;
      ST_COPY: st_d = ST_OUT_RD;
      ST_OUT_RD: begin n_d = '0; a_ra = '0; st_d = ST_OUT; end
      // Gather levels one neuron a cycle
      ST_OUT: begin
        lev_d[2*n_q +: 2] = level_of(act_now);
        n_d = n_q + 1'b1; a_ra = n_q + 1'b1;
        if (n_q == AW'(NeuronCnt - 1)) st_d = ST_EMIT;
      end
      ST_EMIT: begin done_o = 1'b1; st_d = ST_IDLE; end
      default: st_d = ST_IDLE;
    endcase
  end

  assign busy_o = (st_q != ST_IDLE);
  assign res_o.brain_class   = cls_q;
  assign res_o.epoch_now     = epoch_q;
  assign res_o.neuron_levels = lev_q;
endmodule
`default_nettype wire

[rtl/recurrent_net_step_with_noise.sv]
// Channel | Dir | Handshake           | Word
// in      | in  | in_valid_i/in_stall_o | in_word_t
// out     | out | out_valid_o/out_stall_i | out_word_t
// cfg     | in  | cfg_valid_i/cfg_ready_o | index, data
// One word at a time. Seed: fill activations with random values. Step: decay sweep,
// edge sweep (read, then update, per edge) and finish sweep, one read a cycle on each
// RAM. Reconstruct: fill plus 1 to 8 steps. Levels are then gathered and loaded into
// the output register. Reset clears control state; activation RAM reads as zero until
// the first seed or step writes it. A held result stalls intake until taken.
`default_nettype none
module recurrent_net_step_with_noise #(
  parameter int unsigned NeuronCnt = rns_pkg::NeuronCount
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire rns_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output rns_pkg::out_word_t      out_word_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [0:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);
  import rns_pkg::*;
  `include "recurrent_net_step_with_noise_macros.svh"

  logic [31:0] ident_q;
  logic [14:0] thr_q;
  logic        busy, done, start, ov_q;
  out_word_t   res, ow_q;

  assign cfg_ready_o = 1'b1;
  // Hold the register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ident_q <= '0; thr_q <= ThrReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_e'(cfg_index_i))
        CFG_IDENTITY:  ident_q <= cfg_data_i;
        CFG_THRESHOLD: thr_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = busy | ov_q;
  assign start = in_valid_i & ~in_stall_o;

  rns_core #(.NeuronCnt(NeuronCnt)) u_core (
    .clk_i, .rst_ni, .start_i(start), .req_i(in_word_i), .identity_i(ident_q),
    .threshold_i(thr_q), .busy_o(busy), .done_o(done), .res_o(res));

  // Output register, held while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (done) ov_q <= 1'b1;
    else if (!out_stall_i) ov_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (done) ow_q <= res;
  end
  assign out_valid_o = ov_q;
  assign out_word_o  = ow_q;

  `RNS_ASSERT_IMP(a_no_start_busy, clk_i, rst_ni, start, !busy && !ov_q, "start while busy")
  `RNS_ASSERT_NEXT(a_done_valid, clk_i, rst_ni, done, out_valid_o, "result lost")
  `RNS_ASSERT_IMP(a_done_free, clk_i, rst_ni, done, !ov_q, "result overwritten")
endmodule
`default_nettype wire

[tb/recurrent_net_step_with_noise_tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module recurrent_net_step_with_noise_tb;
  import rns_pkg::*;

  localparam int IdleLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_word_t    in_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_word_t   out_word_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = CFG_IDENTITY;
  logic [31:0] cfg_data_i = '0;

  recurrent_net_step_with_noise DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Connection table: source, destination, shift, add (1) or subtract (0)
  int link_tab [78][4] = '{
    '{0,5,2,1}, '{1,6,2,1}, '{2,7,2,1}, '{3,8,2,1}, '{4,9,2,1},
    '{5,6,3,1}, '{6,5,3,1}, '{6,7,3,1}, '{7,6,3,1}, '{7,8,3,1}, '{8,7,3,1},
    '{8,9,3,1}, '{9,8,3,1}, '{9,10,3,1}, '{10,9,3,1}, '{10,11,3,1}, '{11,10,3,1},
    '{11,12,3,1}, '{12,11,3,1}, '{12,5,3,1}, '{5,12,3,1},
    '{5,9,4,0}, '{6,10,4,0}, '{7,11,4,0}, '{8,12,4,0},
    '{9,5,4,0}, '{10,6,4,0}, '{11,7,4,0}, '{12,8,4,0},
    '{5,13,3,1}, '{6,14,3,1}, '{7,15,3,1}, '{8,16,3,1},
    '{9,17,3,1}, '{10,18,3,1}, '{11,19,3,1}, '{12,20,3,1},
    '{13,16,4,1}, '{16,19,4,1}, '{19,22,4,1}, '{22,13,4,1},
    '{14,17,4,1}, '{17,20,4,1}, '{20,23,4,1}, '{23,14,4,1},
    '{15,18,4,1}, '{18,21,4,1}, '{21,24,4,1}, '{24,15,4,1},
    '{13,20,5,0}, '{14,21,5,0}, '{15,22,5,0}, '{16,23,5,0},
    '{17,24,5,0}, '{18,13,5,0},
    '{25,26,5,1}, '{26,27,5,1}, '{27,28,5,1}, '{28,25,5,1},
    '{25,14,5,1}, '{26,17,5,1}, '{27,20,5,1}, '{28,23,5,1},
    '{13,29,3,1}, '{16,29,3,1}, '{19,29,3,1}, '{22,29,3,1},
    '{14,30,3,1}, '{17,30,3,1}, '{20,30,3,1}, '{23,30,3,1},
    '{15,31,3,1}, '{18,31,3,1}, '{21,31,3,1}, '{24,31,3,1},
    '{29,16,5,1}, '{30,19,5,1}, '{31,22,5,1}
  };

  // Network shadow state
  int          net_act [32];
  logic [31:0] net_gen = GenReset;
  logic [31:0] net_epoch = '0;
  logic [1:0]  net_class = 2'd0;
  logic [31:0] net_identity = '0;
  int          net_thresh = int'(ThrReset);

  in_word_t  pend_q [$];
  out_word_t brain_q [$];
  int        err_count = 0;
  int        out_seen = 0;
  int        stall_pct = 0;
  int        gap_max = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  int        idle_cyc = 0;

  initial begin
    for (int n = 0; n < 32; n++) net_act[n] = 0;
  end

  function automatic logic [31:0] draw_noise();
    logic [31:0] v;
    v = net_gen;
    v = v ^ (v << 13);
    v = v ^ (v >> 17);
    v = v ^ (v << 5);
    net_gen = v;
    return v;
  endfunction

  function automatic int clamp_act(int v);
    if (v > 16383) return 16383;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic int abs_act(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void classify_net();
    int mv;
    int ar;
    int qu;
    mv = abs_act(net_act[29]);
    ar = abs_act(net_act[30]);
    qu = abs_act(net_act[31]);
    if (mv >= net_thresh && mv >= ar && mv >= qu) net_class = 2'd1;
    else if (ar >= net_thresh && ar >= qu) net_class = 2'd2;
    else if (qu >= net_thresh) net_class = 2'd3;
    else net_class = 2'd0;
  endfunction

  function automatic void seed_net(logic [31:0] ep);
    logic [31:0] s;
    logic [31:0] r;
    int v;
    s = net_identity ^ (ep << 16) ^ (ep >> 7) ^ SeedMix;
    if (s == 32'd0) s = GenReset;
    net_gen = s;
    net_epoch = ep;
    for (int n = 0; n < 32; n++) begin
      r = draw_noise();
      v = int'(r & 32'h1ff) - 256;
      if (n >= 25 && n <= 28) v = 2 * (int'(r & 32'h7ff) - 1024);
      net_act[n] = clamp_act(v);
    end
    classify_net();
  endfunction

  function automatic void step_net(logic [4:0] mask);
    int nxt [32];
    int c;
    for (int n = 0; n < 32; n++) nxt[n] = (net_act[n] >>> 1) + (net_act[n] >>> 2);
    for (int e = 0; e < 78; e++) begin
      c = net_act[link_tab[e][0]] >>> link_tab[e][2];
      if (link_tab[e][3] != 0) nxt[link_tab[e][1]] += c;
      else nxt[link_tab[e][1]] -= c;
    end
    for (int n = 0; n < 5; n++) if (mask[n]) nxt[n] += 4096;
    for (int n = 0; n < 32; n++)
      net_act[n] = clamp_act(nxt[n] + int'(draw_noise() & 32'h1f) - 16);
    net_epoch = net_epoch + 32'd1;
    classify_net();
  endfunction

  // Advance the shadow network by one request and queue its result
  function automatic void predict_brain(in_word_t w);
    out_word_t o;
    int m;
    case (req_e'(w.req_type))
      REQ_SEED: seed_net(w.epoch_or_tick);
      REQ_STEP: step_net(w.sensory_mask);
      REQ_RECON: begin
        seed_net(w.epoch_or_tick >> 3);
        for (int k = 0; k <= int'(w.epoch_or_tick[2:0]); k++) step_net(w.sensory_mask);
      end
      default: ;
    endcase
    o.brain_class = net_class;
    o.epoch_now = net_epoch;
    o.neuron_levels = '0;
    for (int n = 0; n < 32; n++) begin
      m = abs_act(net_act[n]);
      o.neuron_levels[2*n +: 2] = (m < 128) ? 2'd0 : (m < 256) ? 2'd1 : (m < 512) ? 2'd2 : 2'd3;
    end
    brain_q.push_back(o);
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Driver: send pending words in bursts, hold while stalled
  always @(posedge clk_i or negedge rst_ni) begin : drive_in
    logic     v_next;
    in_word_t w_next;
    int       burst_left;
    int       gap_left;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      v_next = in_valid_i;
      w_next = in_word_i;
      if (in_valid_i && !in_stall_o) begin
        void'(pend_q.pop_front());
        predict_brain(in_word_i);
        v_next = 1'b0;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          v_next = 1'b0;
        end else if (pend_q.size() > 0) begin
          v_next = 1'b1;
          w_next = pend_q[0];
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, gap_max);
          end
        end else begin
          v_next = 1'b0;
        end
      end
      in_valid_i <= v_next;
      in_word_i <= w_next;
    end
  end

  // Monitor: check each taken word against the oldest prediction, drive stall
  always @(posedge clk_i or negedge rst_ni) begin : watch_out
    out_word_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        out_seen++;
        if (brain_q.size() == 0) begin
          $error("unexpected word: class %0d epoch %0h", out_word_o.brain_class,
                 out_word_o.epoch_now);
          err_count++;
        end else begin
          want = brain_q.pop_front();
          if (out_word_o.brain_class !== want.brain_class) begin
            $error("brain_class: expected %0d actual %0d", want.brain_class,
                   out_word_o.brain_class);
            err_count++;
          end
          if (out_word_o.epoch_now !== want.epoch_now) begin
            $error("epoch_now: expected %0h actual %0h", want.epoch_now,
                   out_word_o.epoch_now);
            err_count++;
          end
          if (out_word_o.neuron_levels !== want.neuron_levels) begin
            $error("neuron_levels: expected %016h actual %016h", want.neuron_levels,
                   out_word_o.neuron_levels);
            err_count++;
          end
        end
      end
      // Long hold-off once, so the block backs up against its input
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!hold_done && out_seen >= 200) begin
        hold_done = 1'b1;
        hold_left = 5000;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cyc = 0;
    end else begin
      idle_cyc++;
      if (idle_cyc >= IdleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic queue_word(req_e r, logic [31:0] arg, logic [4:0] mask);
    in_word_t w;
    w.req_type = r;
    w.epoch_or_tick = arg;
    w.sensory_mask = mask;
    @(negedge clk_i);
    pend_q.push_back(w);
  endtask

  task automatic write_reg(cfg_e idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_IDENTITY) net_identity = data;
    else net_thresh = int'(data[14:0]);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_all();
    do @(posedge clk_i); while (pend_q.size() != 0 || brain_q.size() != 0 || in_valid_i);
  endtask

  // Mostly seeded runs of steps with random content, some noise words mixed in
  task automatic queue_random(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) queue_word(REQ_SEED, $urandom, 5'($urandom));
      else if (pick < 22) queue_word(REQ_RECON, $urandom, 5'($urandom));
      else if (pick < 27) queue_word(REQ_NONE, $urandom, 5'($urandom));
      else if (pick < 60) queue_word(REQ_STEP, $urandom, 5'h1f);
      else queue_word(REQ_STEP, $urandom, 5'($urandom));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: step and idle request on cleared store, seeds, masks, reconstructs
    queue_word(REQ_STEP, 32'hffffffff, 5'h00);
    queue_word(REQ_NONE, 32'h0, 5'h1f);
    queue_word(REQ_SEED, 32'h0, 5'h00);
    queue_word(REQ_STEP, 32'h0, 5'h1f);
    for (int b = 0; b < 5; b++) queue_word(REQ_STEP, 32'h0, 5'(1 << b));
    queue_word(REQ_SEED, 32'hffffffff, 5'h1f);
    queue_word(REQ_STEP, 32'h12345678, 5'h1f);
    queue_word(REQ_RECON, 32'h0, 5'h1f);
    queue_word(REQ_RECON, 32'h7, 5'h1f);
    queue_word(REQ_RECON, 32'hffffffff, 5'h00);
    queue_word(REQ_NONE, 32'hffffffff, 5'h00);
    drain_all();

    // Zero seed case, wide thresholds
    write_reg(CFG_IDENTITY, SeedMix);
    write_reg(CFG_THRESHOLD, 32'd0);
    queue_word(REQ_SEED, 32'h0, 5'h00);
    queue_word(REQ_RECON, 32'h3, 5'h15);
    queue_word(REQ_STEP, 32'h0, 5'h0a);
    drain_all();
    write_reg(CFG_THRESHOLD, 32'h7fff);
    queue_word(REQ_SEED, 32'h5, 5'h00);
    queue_word(REQ_STEP, 32'h0, 5'h1f);
    drain_all();

    // Random phases, each with its own settings and pacing
    gap_max = 6;  stall_pct = 20;
    write_reg(CFG_IDENTITY, $urandom);
    write_reg(CFG_THRESHOLD, 32'd512);
    queue_random(110);
    drain_all();
    gap_max = 0;  stall_pct = 0;
    write_reg(CFG_IDENTITY, 32'h0);
    write_reg(CFG_THRESHOLD, 32'd16384);
    queue_random(110);
    drain_all();
    gap_max = 40; stall_pct = 70;
    write_reg(CFG_IDENTITY, 32'hffffffff);
    write_reg(CFG_THRESHOLD, 32'd1);
    queue_random(110);
    drain_all();
    gap_max = 3;  stall_pct = 40;
    write_reg(CFG_IDENTITY, $urandom);
    write_reg(CFG_THRESHOLD, 32'($urandom_range(0, 2048)));
    queue_random(110);
    drain_all();
    gap_max = 10; stall_pct = 10;
    write_reg(CFG_IDENTITY, $urandom);
    write_reg(CFG_THRESHOLD, 32'd16383);
    queue_random(110);
    drain_all();

    repeat (100) @(posedge clk_i);
    if (err_count == 0 && brain_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire

[recurrent_net_step_with_noise.f]
+incdir+rtl
rtl/rns_pkg.sv
rtl/rns_ram.sv
rtl/rns_core.sv
rtl/recurrent_net_step_with_noise.sv
tb/recurrent_net_step_with_noise_tb.sv
